### rtl/wsd_pkg.sv
package wsd_pkg;

  // Width of the stored payload length; extended lengths above its range saturate.
  localparam int LENGTH_BITS = 64;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;

  localparam logic [1:0] ACT_TEXT   = 2'd0;
  localparam logic [1:0] ACT_PONG   = 2'd1;
  localparam logic [1:0] ACT_CLOSE  = 2'd2;
  localparam logic [1:0] ACT_IGNORE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       conn_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] frame_opcode;
    logic       final_flag;
    logic [1:0] action;
    logic       frame_end;
  } out_word_t;

endpackage

### rtl/wsd_parser.sv
module wsd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  wsd_pkg::in_word_t  in_word,
  output logic             res_valid,
  output wsd_pkg::out_word_t res_word
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CLOSED  = 3'd5
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  phase_t                 phase_r, phase_nxt, ph_cur;
  logic                   fin_r, fin_nxt, fin_cur;
  logic [3:0]             op_r, op_nxt, op_cur;
  logic                   masked_r, masked_nxt, masked_cur;
  logic [3:0]             hbl_r, hbl_nxt, hbl_cur, hbl_dec;
  logic [LENGTH_BITS-1:0] len_r, len_nxt, len_cur, len_shift, len_final, len_known;
  logic                   ovf_r, ovf_nxt, ovf_cur, ovf_shift;
  logic [31:0]            key_r, key_nxt, key_cur;
  logic [1:0]             kidx_r, kidx_nxt, kidx_cur;
  logic [7:0]             b, key_byte;
  logic                   close_frame;

  function automatic logic [1:0] action_of(input logic [3:0] op);
    logic [1:0] a;
    case (op)
      OP_TEXT:  a = ACT_TEXT;
      OP_PING:  a = ACT_PONG;
      OP_CLOSE: a = ACT_CLOSE;
      default:  a = ACT_IGNORE;
    endcase
    return a;
  endfunction

  always_comb begin
    b = in_word.data_byte;
    // a new connection starts from the reset state before this word is parsed
    ph_cur     = in_word.conn_start ? PH_HDR0 : phase_r;
    fin_cur    = in_word.conn_start ? 1'b0 : fin_r;
    op_cur     = in_word.conn_start ? 4'd0 : op_r;
    masked_cur = in_word.conn_start ? 1'b0 : masked_r;
    hbl_cur    = in_word.conn_start ? 4'd0 : hbl_r;
    len_cur    = in_word.conn_start ? '0 : len_r;
    ovf_cur    = in_word.conn_start ? 1'b0 : ovf_r;
    key_cur    = in_word.conn_start ? 32'd0 : key_r;
    kidx_cur   = in_word.conn_start ? 2'd0 : kidx_r;

    hbl_dec   = hbl_cur - 4'd1;
    len_shift = {len_cur[LENGTH_BITS-9:0], b};
    ovf_shift = ovf_cur | (len_cur[LENGTH_BITS-1 -: 8] != 8'd0);
    len_final = ovf_shift ? LEN_MAX : len_shift;
    close_frame = (op_cur == OP_CLOSE);

    case (kidx_cur)
      2'd0:    key_byte = key_cur[31:24];
      2'd1:    key_byte = key_cur[23:16];
      2'd2:    key_byte = key_cur[15:8];
      default: key_byte = key_cur[7:0];
    endcase
    if (!masked_cur) key_byte = 8'd0;

    phase_nxt  = ph_cur;
    fin_nxt    = fin_cur;
    op_nxt     = op_cur;
    masked_nxt = masked_cur;
    hbl_nxt    = hbl_cur;
    len_nxt    = len_cur;
    ovf_nxt    = ovf_cur;
    key_nxt    = key_cur;
    kidx_nxt   = kidx_cur;
    len_known  = len_cur;

    res_valid             = 1'b0;
    res_word.payload_byte = 8'd0;
    res_word.has_byte     = 1'b0;
    res_word.frame_opcode = op_cur;
    res_word.final_flag   = fin_cur;
    res_word.action       = action_of(op_cur);
    res_word.frame_end    = 1'b1;

    case (ph_cur)
      PH_HDR0: begin
        fin_nxt   = b[7];
        op_nxt    = b[3:0];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1, PH_EXTLEN, PH_MASK: begin
        // settle the length, then either fetch the key or finish the header
        logic length_done;
        logic header_end;
        length_done = 1'b0;
        header_end  = 1'b0;
        if (ph_cur == PH_HDR1) begin
          masked_nxt = b[7];
          ovf_nxt    = 1'b0;
          len_nxt    = '0;
          if (b[6:0] == LEN16_CODE) begin
            hbl_nxt   = 4'd2;
            phase_nxt = PH_EXTLEN;
          end else if (b[6:0] == LEN64_CODE) begin
            hbl_nxt   = 4'd8;
            phase_nxt = PH_EXTLEN;
          end else begin
            len_known   = LENGTH_BITS'(b[6:0]);
            len_nxt     = len_known;
            length_done = 1'b1;
          end
        end else if (ph_cur == PH_EXTLEN) begin
          hbl_nxt = hbl_dec;
          len_nxt = len_shift;
          ovf_nxt = ovf_shift;
          if (hbl_dec == 4'd0) begin
            len_known   = len_final;
            len_nxt     = len_final;
            length_done = 1'b1;
          end
        end else begin
          key_nxt   = {key_cur[23:0], b};
          hbl_nxt   = hbl_dec;
          len_known = len_cur;
          if (hbl_dec == 4'd0) header_end = 1'b1;
        end

        if (length_done) begin
          if (masked_nxt) begin
            hbl_nxt   = 4'd4;
            key_nxt   = 32'd0;
            phase_nxt = PH_MASK;
          end else begin
            header_end = 1'b1;
          end
        end

        if (header_end) begin
          kidx_nxt = 2'd0;
          if (len_known == '0) begin
            // empty payload: post a notice and close out the frame
            res_valid = 1'b1;
            phase_nxt = close_frame ? PH_CLOSED : PH_HDR0;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        kidx_nxt              = kidx_cur + 2'd1;
        len_nxt               = len_cur - LENGTH_BITS'(1);
        res_valid             = 1'b1;
        res_word.payload_byte = b ^ key_byte;
        res_word.has_byte     = 1'b1;
        res_word.frame_end    = (len_cur == LENGTH_BITS'(1));
        if (len_cur == LENGTH_BITS'(1)) phase_nxt = close_frame ? PH_CLOSED : PH_HDR0;
      end
      PH_CLOSED: begin
        phase_nxt = PH_CLOSED;
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      fin_r    <= 1'b0;
      op_r     <= 4'd0;
      masked_r <= 1'b0;
      hbl_r    <= 4'd0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      key_r    <= 32'd0;
      kidx_r   <= 2'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      op_r     <= op_nxt;
      masked_r <= masked_nxt;
      hbl_r    <= hbl_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      key_r    <= key_nxt;
      kidx_r   <= kidx_nxt;
    end
  end

endmodule

### rtl/wsd_out_reg.sv
module wsd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wsd_pkg::out_word_t push_word,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output wsd_pkg::out_word_t out_word
);
  import wsd_pkg::*;

  logic      valid_r;
  out_word_t word_r;

  // accept upstream whenever the held word leaves this cycle or there is none
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) word_r <= push_word;
  end

endmodule

### rtl/websocket_frame_deframer.sv
// Receive-side WebSocket frame parser: takes one stream word (byte) per cycle, sustained,
// and returns each payload byte unmasked, tagged with opcode, FIN, an action code and an
// end-of-frame mark; a frame with an empty payload yields one notice word with has_byte
// low. Header and mask-key words give no result. The parse state and the word's result
// are both registered at the edge that accepts the word, so a result is offered on
// out_valid in the very next cycle. The output register alone sets the rate: a new word
// is taken every cycle unless a result is held there with out_ready low, and while it is
// held no word is taken, header words included. After a close frame all words are dropped
// until one arrives with conn_start high, which restarts the parser at that word.
module websocket_frame_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wsd_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output wsd_pkg::out_word_t out_word
);
  import wsd_pkg::*;

  logic      in_fire;
  logic      res_valid;
  out_word_t res_word;

  // advance the parser only on an accepted word
  assign in_fire = in_valid && in_ready;

  // header walk, length capture, mask key, payload unmasking
  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_fire),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // hold the result until the consumer takes it
  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && res_valid),
    .push_word (res_word),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

### tb/tb_websocket_frame_deframer.sv
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  // Opcodes with no special handling of their own; they map to the ignore action.
  localparam logic [3:0] OP_CONT = 4'd0;
  localparam logic [3:0] OP_PONG = 4'd10;

  // How a frame header states its payload length.
  localparam int LEN_SHORT = 0;
  localparam int LEN_EXT16 = 1;
  localparam int LEN_EXT64 = 2;

  // Largest length the parser keeps; wider extended lengths saturate to it.
  localparam logic [63:0] LEN_CAP = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD, PH_CLOSED
  } parse_phase_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  websocket_frame_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stream words waiting to be sent, and the deframed words still owed by the block.
  in_word_t  pending_words[$];
  out_word_t expected_words[$];

  int  stream_words = 0;  // parsed words queued so far; discarded words do not count
  bit  restart_next = 1'b1;  // mark the next queued word with conn_start
  int  mismatches = 0;
  bit  draining = 1'b0;
  int  in_gap = 0;
  int  in_calm = 0;
  int  out_stall = 0;
  int  out_calm = 0;

  // Parser mirror: tracks the header walk and payload unmasking word by word.
  parse_phase_t rx_phase;
  logic         rx_fin;
  logic [3:0]   rx_op;
  logic         rx_masked;
  logic [3:0]   rx_hdr_left;
  logic [63:0]  rx_left;
  logic [31:0]  rx_key;
  logic [1:0]   rx_key_idx;

  function automatic void clear_parser();
    rx_phase    = PH_HDR0;
    rx_fin      = 1'b0;
    rx_op       = '0;
    rx_masked   = 1'b0;
    rx_hdr_left = '0;
    rx_left     = '0;
    rx_key      = '0;
    rx_key_idx  = '0;
  endfunction

  function automatic void push_result(logic [7:0] data, logic has, logic last);
    out_word_t w;
    w.payload_byte = data;
    w.has_byte     = has;
    w.frame_opcode = rx_op;
    w.final_flag   = rx_fin;
    w.frame_end    = last;
    case (rx_op)
      OP_TEXT:  w.action = ACT_TEXT;
      OP_PING:  w.action = ACT_PONG;
      OP_CLOSE: w.action = ACT_CLOSE;
      default:  w.action = ACT_IGNORE;
    endcase
    expected_words.push_back(w);
  endfunction

  // A finished close frame locks the parser until the next conn_start.
  function automatic void frame_closed();
    rx_phase = (rx_op == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
  endfunction

  // Header and key are in: either announce an empty frame or start the payload.
  function automatic void header_closed();
    rx_key_idx = '0;
    if (rx_left == 0) begin
      push_result(8'h00, 1'b0, 1'b1);
      frame_closed();
    end else begin
      rx_phase = PH_PAYLOAD;
    end
  endfunction

  function automatic void length_settled();
    if (rx_masked) begin
      rx_hdr_left = 4'd4;
      rx_key      = '0;
      rx_phase    = PH_MASK;
    end else begin
      header_closed();
    end
  endfunction

  // Advance the parser mirror by one accepted stream word.
  function automatic void deframe_word(in_word_t w);
    logic [7:0] b;
    logic [7:0] key_byte;
    logic [6:0] len7;
    b = w.data_byte;
    if (w.conn_start)
      clear_parser();
    case (rx_phase)
      PH_HDR0: begin
        rx_fin   = b[7];
        rx_op    = b[3:0];
        rx_phase = PH_HDR1;
      end
      PH_HDR1: begin
        rx_masked = b[7];
        len7      = b[6:0];
        rx_left   = '0;
        if (len7 == LEN16_CODE) begin
          rx_hdr_left = 4'd2;
          rx_phase    = PH_EXTLEN;
        end else if (len7 == LEN64_CODE) begin
          rx_hdr_left = 4'd8;
          rx_phase    = PH_EXTLEN;
        end else begin
          rx_left = 64'(len7);
          length_settled();
        end
      end
      PH_EXTLEN: begin
        rx_left = {rx_left[55:0], b};
        rx_hdr_left--;
        if (rx_hdr_left == 0) begin
          if (rx_left > LEN_CAP)
            rx_left = LEN_CAP;
          length_settled();
        end
      end
      PH_MASK: begin
        rx_key = {rx_key[23:0], b};
        rx_hdr_left--;
        if (rx_hdr_left == 0)
          header_closed();
      end
      PH_PAYLOAD: begin
        // Key byte 0 is the first one on the wire, so it sits in the top byte.
        key_byte = rx_masked ? rx_key[31 - 8 * rx_key_idx -: 8] : 8'h00;
        rx_key_idx++;
        rx_left--;
        push_result(b ^ key_byte, 1'b1, rx_left == 0);
        if (rx_left == 0)
          frame_closed();
      end
      default: ;  // closed: drop the word
    endcase
  endfunction

  // Mostly back-to-back, often short gaps, now and then a long one, and
  // occasional calm stretches with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int roll;
    roll = $urandom_range(0, 999);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 8) begin
      calm = $urandom_range(40, 250);
      return 0;
    end
    if (roll < 550)
      return 0;
    if (roll < 850)
      return $urandom_range(1, 3);
    if (roll < 970)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_word(input logic [7:0] b, input bit counted);
    in_word_t w;
    w.data_byte  = b;
    w.conn_start = restart_next;
    restart_next = 1'b0;
    pending_words.push_back(w);
    if (counted)
      stream_words++;
  endtask

  // Queue one frame. A cut of zero or more sends only that many payload words
  // and marks the next word with conn_start; a negative cut sends the whole payload.
  task automatic send_frame(input logic [3:0] op, input logic fin, input logic mask_on,
                            input int len_form, input logic [63:0] len, input int cut);
    logic [6:0]      len7;
    longint unsigned n;
    push_word({fin, 3'($urandom_range(0, 7)), op}, 1'b1);
    case (len_form)
      LEN_EXT16: len7 = LEN16_CODE;
      LEN_EXT64: len7 = LEN64_CODE;
      default:   len7 = len[6:0];
    endcase
    push_word({mask_on, len7}, 1'b1);
    if (len_form == LEN_EXT16) begin
      push_word(len[15:8], 1'b1);
      push_word(len[7:0], 1'b1);
    end else if (len_form == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--)
        push_word(len[8 * i +: 8], 1'b1);
    end
    if (mask_on)
      repeat (4) push_word(8'($urandom), 1'b1);
    n = (cut >= 0) ? longint'(cut) : len;
    for (longint unsigned k = 0; k < n; k++)
      push_word(8'($urandom), 1'b1);
    if (cut >= 0) begin
      restart_next = 1'b1;
    end else if (op == OP_CLOSE) begin
      // Trail a few words the locked parser must drop, then reopen the link.
      repeat ($urandom_range(0, 3)) push_word(8'($urandom), 1'b0);
      restart_next = 1'b1;
    end
  endtask

  // Driver: hold the word until accepted, then advance to the next one after a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word  <= pending_words.pop_front();
        in_valid <= 1'b1;
        in_gap   <= pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, keep ready high while draining at the end.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (draining) begin
      out_ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall <= pick_gap(out_calm);
    end
  end

  // Monitor: predict from each accepted stream word first, then check the
  // deframed word accepted at this edge against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (in_valid && in_ready)
        deframe_word(in_word);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("deframed word with nothing expected: %p", out_word);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("payload_byte", want.payload_byte, out_word.payload_byte);
          check_field("has_byte", want.has_byte, out_word.has_byte);
          check_field("frame_opcode", want.frame_opcode, out_word.frame_opcode);
          check_field("final_flag", want.final_flag, out_word.final_flag);
          check_field("action", want.action, out_word.action);
          check_field("frame_end", want.frame_end, out_word.frame_end);
        end
      end
    end
  end

  initial begin
    int          roll;
    int          len_form;
    int          cut;
    logic [3:0]  op;
    logic [63:0] len;

    // Directed frames: payload extremes, masked ping, empty frame with reserved
    // bits set, empty close followed by a dropped word, and the largest 64-bit length.
    push_word({1'b1, 3'b000, OP_TEXT}, 1'b1);
    push_word({1'b0, 7'd2}, 1'b1);
    push_word(8'h00, 1'b1);
    push_word(8'hFF, 1'b1);
    push_word({1'b1, 3'b000, OP_PING}, 1'b1);
    push_word({1'b1, 7'd1}, 1'b1);
    push_word(8'hFF, 1'b1);
    push_word(8'h00, 1'b1);
    push_word(8'hA5, 1'b1);
    push_word(8'h5A, 1'b1);
    push_word(8'hFF, 1'b1);
    push_word({1'b0, 3'b111, OP_PONG}, 1'b1);
    push_word({1'b0, 7'd0}, 1'b1);
    push_word({1'b1, 3'b000, OP_CLOSE}, 1'b1);
    push_word({1'b0, 7'd0}, 1'b1);
    push_word({1'b1, 3'b000, OP_TEXT}, 1'b0);
    restart_next = 1'b1;
    push_word({1'b1, 3'b000, OP_TEXT}, 1'b1);
    push_word({1'b0, LEN64_CODE}, 1'b1);
    repeat (8) push_word(8'hFF, 1'b1);
    push_word(8'h7E, 1'b1);
    restart_next = 1'b1;

    // Random frames: mostly well formed, some cut short, some plain noise.
    while (stream_words < 1900) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        repeat ($urandom_range(1, 3)) push_word(8'($urandom), 1'b1);
        restart_next = 1'b1;
        continue;
      end
      if ($urandom_range(0, 11) == 0)
        restart_next = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 35)      op = OP_TEXT;
      else if (roll < 50) op = OP_PING;
      else if (roll < 58) op = OP_CLOSE;
      else if (roll < 68) op = OP_CONT;
      else                op = 4'($urandom_range(0, 15));
      cut = -1;
      len_form = LEN_SHORT;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        len = 0;
      end else if (roll < 70) begin
        len = $urandom_range(1, 16);
      end else if (roll < 78) begin
        len = $urandom_range(17, 125);
      end else if (roll < 86) begin
        len_form = LEN_EXT16;
        len = $urandom_range(0, 40);
      end else if (roll < 92) begin
        len_form = LEN_EXT64;
        len = $urandom_range(0, 40);
      end else if (roll < 96) begin
        len_form = LEN_EXT16;
        len = $urandom_range(100, 300);
      end else begin
        // Huge length: send a few payload words, then abandon the frame.
        len_form = $urandom_range(0, 1) ? LEN_EXT64 : LEN_EXT16;
        len = (len_form == LEN_EXT64) ? {$urandom, $urandom} : 64'($urandom_range(0, 65535));
        cut = $urandom_range(0, 12);
      end
      if (cut < 0 && len > 2 && $urandom_range(0, 19) == 0)
        cut = $urandom_range(0, int'(len) - 1);
      send_frame(op, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, len_form, len, cut);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the driver's updates have settled.
    while (pending_words.size() != 0 || in_valid)
      @(negedge clk);
    while (expected_words.size() != 0)
      @(negedge clk);
    // Open the output and watch a little longer for stray words.
    draining = 1'b1;
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
